// ----- src/fmva_pkg.sv -----
// Package for the FM voice channel allocator: opcodes, kind codes, list cell types.
// No dependencies.
package fmva_pkg;

  localparam int unsigned PhysChannels = 18;
  localparam int unsigned PairBases    = 6;
  localparam int unsigned DrumCount    = 5;
  localparam int unsigned AllChannels  = PhysChannels + DrumCount;

  typedef enum logic [2:0] {
    MODE_ALLOC   = 3'd0,
    MODE_FREE    = 3'd1,
    MODE_DRUM_ON = 3'd2,
    MODE_DRUM_OF = 3'd3,
    MODE_KEY_ON  = 3'd4,
    MODE_KEY_OFF = 3'd5
  } mode_e;

  localparam logic [2:0] VkTwo  = 3'd1;
  localparam logic [2:0] VkFour = 3'd2;
  localparam logic [2:0] VkKick = 3'd3;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindTwo  = 2'd1;
  localparam logic [1:0] KindFour = 2'd2;

  typedef logic [4:0] chan_t;

  // Command broadcast to every cell of a list in each pass.
  typedef enum logic [1:0] {
    LOP_IDLE   = 2'd0,
    LOP_SHIFT  = 2'd1,
    LOP_REMOVE = 2'd2,
    LOP_DROP68 = 2'd3
  } lop_e;

  typedef struct packed {
    lop_e  op;
    chan_t ch;
  } lcmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PASS = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  function automatic logic [4:0] pair_base(input logic [2:0] i);
    logic [4:0] r;
    begin
      unique case (i)
        3'd0: r = 5'd0;
        3'd1: r = 5'd1;
        3'd2: r = 5'd2;
        3'd3: r = 5'd9;
        3'd4: r = 5'd10;
        3'd5: r = 5'd11;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- src/fmva_cell.sv -----
// One entry of a free list; compacts toward the head by taking its right neighbor.
// Depends on fmva_pkg.
module fmva_cell #(
  parameter fmva_pkg::chan_t RstVal = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_i,
  input  fmva_pkg::chan_t   init_val_i,
  input  fmva_pkg::lcmd_t   cmd_i,
  input  logic              kill_i,
  input  logic              write_i,
  input  fmva_pkg::chan_t   write_val_i,
  input  fmva_pkg::chan_t   right_i,
  input  logic              found_left_i,
  output logic              found_o,
  output fmva_pkg::chan_t   val_o
);

  fmva_pkg::chan_t val_q, val_d;
  logic match;

  // Removal match propagates rightward: this cell and all after the hit shift.
  assign match   = (cmd_i.op == fmva_pkg::LOP_REMOVE) && (val_q == cmd_i.ch) && !kill_i;
  assign found_o = found_left_i | match;

  always_comb begin
    val_d = val_q;
    if (write_i) begin
      val_d = write_val_i;
    end else if (cmd_i.op == fmva_pkg::LOP_SHIFT || found_o) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= RstVal;
    end else if (init_i) begin
      val_q <= init_val_i;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// ----- src/fmva_list.sv -----
// Ordered free list built as a chain of cells with a fill count.
// Depends on fmva_pkg and fmva_cell.
module fmva_list #(
  parameter int unsigned Depth = 18,
  parameter bit          InitSeq = 1'b1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fmva_pkg::lcmd_t            cmd_i,
  input  logic                       push_i,
  input  fmva_pkg::chan_t            push_val_i,
  output logic [$clog2(Depth+1)-1:0] count_o,
  output fmva_pkg::chan_t            head_o
);

  localparam int unsigned CW = $clog2(Depth + 1);

  logic [CW-1:0] count_q, count_d;
  fmva_pkg::chan_t vals [Depth];
  logic            found [Depth+1];
  logic            removed;
  logic [CW-1:0]   live_cnt;

  assign found[0] = 1'b0;

  fmva_pkg::lcmd_t ccmd;
  always_comb begin
    ccmd = cmd_i;
    if (cmd_i.op == fmva_pkg::LOP_DROP68) begin
      ccmd.op = fmva_pkg::LOP_IDLE;
    end
  end

  generate
    for (genvar g = 0; g < Depth; g++) begin : g_cell
      fmva_pkg::chan_t right;
      logic            kill;
      logic            wr;
      if (g == Depth - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid
        assign right = vals[g+1];
      end
      assign kill = (CW'(g) >= count_q);
      assign wr   = push_i && (count_d == CW'(g + 1)) && (count_q < CW'(Depth));
      fmva_cell #(
        .RstVal (InitSeq ? fmva_pkg::chan_t'(g) : fmva_pkg::chan_t'(0))
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .init_i       (1'b0),
        .init_val_i   ('0),
        .cmd_i        (ccmd),
        .kill_i       (kill),
        .write_i      (wr),
        .write_val_i  (push_val_i),
        .right_i      (right),
        .found_left_i (found[g]),
        .found_o      (found[g+1]),
        .val_o        (vals[g])
      );
    end
  endgenerate

  assign removed  = found[Depth];
  assign live_cnt = count_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.op == fmva_pkg::LOP_SHIFT && count_q != '0) begin
      count_d = count_q - CW'(1);
    end else if (removed) begin
      count_d = count_q - CW'(1);
    end
    if (push_i && count_d < CW'(Depth)) begin
      count_d = count_d + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= InitSeq ? CW'(Depth) : '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = live_cnt;
  assign head_o  = vals[0];

endmodule

// ----- src/fm_voice_channel_allocator.sv -----
// Top level of the FM voice channel allocator.
// Depends on fmva_pkg and fmva_list.
// A 4-op pair conversion removes its two channels from the two-op list in separate passes;
// percussion enable or disable makes one pass per channel 6..8.
// One transaction in flight; the next input is taken in the cycle after the result leaves unstalled.
// Reset: asynchronous, active low; lists, kinds, bitmap and flags return to power-on values.
module fm_voice_channel_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [2:0] voice_kind_i,
  input  logic [4:0] channel_id_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       ok_o,
  output logic [4:0] granted_channel_o,
  output logic       mask_update_o,
  output logic [5:0] four_op_mask_o
);

  localparam int unsigned PHYS_CHANNELS = fmva_pkg::PhysChannels;
  localparam int unsigned PAIR_BASES    = fmva_pkg::PairBases;
  localparam int unsigned TW = $clog2(PHYS_CHANNELS + 1);
  localparam int unsigned FW = $clog2(PAIR_BASES + 1);
  localparam int unsigned AC = PHYS_CHANNELS + fmva_pkg::DrumCount;

  fmva_pkg::state_e state_q, state_d;
  logic [2:0]       mode_q;
  logic [2:0]       kind_q;
  logic [4:0]       ch_q;
  logic [1:0]       step_q, step_d;

  logic [AC-1:0]    alloc_q, alloc_d;
  logic [1:0]       ktab_q [PHYS_CHANNELS];
  logic [1:0]       ktab_d [PHYS_CHANNELS];
  logic             drum_q, drum_d;
  logic [4:0]       keys_q, keys_d;

  logic             ok_q, ok_d;
  logic [4:0]       gr_q, gr_d;
  logic             mu_q, mu_d;
  logic             ov_q;

  fmva_pkg::lcmd_t  two_cmd, four_cmd;
  logic             two_push, four_push;
  fmva_pkg::chan_t  two_pv, four_pv;
  logic [TW-1:0]    two_cnt;
  logic [FW-1:0]    four_cnt;
  fmva_pkg::chan_t  two_head, four_head;

  fmva_list #(.Depth(PHYS_CHANNELS), .InitSeq(1'b1)) u_two (
    .clk_i, .rst_ni, .cmd_i(two_cmd), .push_i(two_push), .push_val_i(two_pv),
    .count_o(two_cnt), .head_o(two_head)
  );

  fmva_list #(.Depth(PAIR_BASES), .InitSeq(1'b0)) u_four (
    .clk_i, .rst_ni, .cmd_i(four_cmd), .push_i(four_push), .push_val_i(four_pv),
    .count_o(four_cnt), .head_o(four_head)
  );

  function automatic logic used(input logic [AC-1:0] m, input logic [4:0] c);
    return (32'(c) < AC) && m[c];
  endfunction

  logic [5:0] mask;
  always_comb begin
    for (int i = 0; i < PAIR_BASES; i++) begin
      mask[i] = (ktab_q[fmva_pkg::pair_base(3'(i))] == fmva_pkg::KindFour);
    end
  end

  logic [2:0] pi2, pi4;
  logic       pf2, pf4;
  always_comb begin
    pf2 = 1'b0; pf4 = 1'b0; pi2 = '0; pi4 = '0;
    for (int i = PAIR_BASES - 1; i >= 0; i--) begin
      logic [4:0] c;
      c = fmva_pkg::pair_base(3'(i));
      if (ktab_q[c] == fmva_pkg::KindFour && ktab_q[c+5'd3] == fmva_pkg::KindNone &&
          !alloc_q[c] && !alloc_q[c+5'd3]) begin
        pf2 = 1'b1; pi2 = 3'(i);
      end
      if (ktab_q[c] == fmva_pkg::KindTwo && ktab_q[c+5'd3] == fmva_pkg::KindTwo &&
          !alloc_q[c] && !alloc_q[c+5'd3]) begin
        pf4 = 1'b1; pi4 = 3'(i);
      end
    end
  end

  logic [4:0] b2, b4, dch;
  logic [1:0] fk;
  assign b2  = fmva_pkg::pair_base(pi2);
  assign b4  = fmva_pkg::pair_base(pi4);
  assign dch = 5'(PHYS_CHANNELS) + (kind_q - fmva_pkg::VkKick);

  always_comb begin
    state_d = state_q; step_d = step_q;
    alloc_d = alloc_q; ktab_d = ktab_q; drum_d = drum_q; keys_d = keys_q;
    ok_d = ok_q; gr_d = gr_q; mu_d = mu_q;
    two_cmd = '{op: fmva_pkg::LOP_IDLE, ch: '0};
    four_cmd = '{op: fmva_pkg::LOP_IDLE, ch: '0};
    two_push = 1'b0; four_push = 1'b0; two_pv = '0; four_pv = '0;
    fk = (32'(ch_q) < PHYS_CHANNELS) ? ktab_q[ch_q[4:0]] :
         (drum_q ? fmva_pkg::KindFour + 2'd1 : fmva_pkg::KindNone);
    unique case (state_q)
      fmva_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = fmva_pkg::ST_PASS;
        end
      end
      fmva_pkg::ST_PASS: begin
        state_d = fmva_pkg::ST_DONE;
        ok_d = 1'b0; gr_d = '0; mu_d = 1'b0;
        unique case (mode_q)
          fmva_pkg::MODE_ALLOC: begin
            if (kind_q == fmva_pkg::VkTwo) begin
              if (two_cnt != '0) begin
                two_cmd.op = fmva_pkg::LOP_SHIFT;
                ok_d = 1'b1; gr_d = two_head; alloc_d[two_head] = 1'b1;
              end else if (pf2) begin
                four_cmd = '{op: fmva_pkg::LOP_REMOVE, ch: b2};
                two_push = 1'b1; two_pv = b2 + 5'd3;
                ktab_d[b2] = fmva_pkg::KindTwo; ktab_d[b2+5'd3] = fmva_pkg::KindTwo;
                ok_d = 1'b1; gr_d = b2; mu_d = 1'b1; alloc_d[b2] = 1'b1;
              end
            end else if (kind_q == fmva_pkg::VkFour) begin
              if (four_cnt != '0) begin
                four_cmd.op = fmva_pkg::LOP_SHIFT;
                ok_d = 1'b1; gr_d = four_head; alloc_d[four_head] = 1'b1;
              end else if (pf4) begin
                if (step_q == 2'd0) begin
                  two_cmd = '{op: fmva_pkg::LOP_REMOVE, ch: b4};
                  step_d = 2'd1; state_d = fmva_pkg::ST_PASS;
                end else begin
                  two_cmd = '{op: fmva_pkg::LOP_REMOVE, ch: b4 + 5'd3};
                  ktab_d[b4] = fmva_pkg::KindFour; ktab_d[b4+5'd3] = fmva_pkg::KindNone;
                  ok_d = 1'b1; gr_d = b4; mu_d = 1'b1; alloc_d[b4] = 1'b1;
                end
              end
            end else if (kind_q >= fmva_pkg::VkKick) begin
              if (drum_q && !alloc_q[dch]) begin
                ok_d = 1'b1; gr_d = dch; alloc_d[dch] = 1'b1;
              end
            end
          end
          fmva_pkg::MODE_FREE: begin
            if (used(alloc_q, ch_q) && fk != fmva_pkg::KindNone) begin
              ok_d = 1'b1; alloc_d[ch_q] = 1'b0;
              if (fk == fmva_pkg::KindTwo) begin
                two_push = 1'b1; two_pv = ch_q;
              end else if (fk == fmva_pkg::KindFour) begin
                four_push = 1'b1; four_pv = ch_q;
              end
            end
          end
          fmva_pkg::MODE_DRUM_ON: begin
            if (drum_q && step_q == 2'd0) begin
              ok_d = 1'b1;
            end else if (step_q == 2'd0 && (alloc_q[6] || alloc_q[7] || alloc_q[8])) begin
              ok_d = 1'b0;
            end else begin
              two_cmd = '{op: fmva_pkg::LOP_REMOVE, ch: 5'd6 + 5'(step_q)};
              drum_d = 1'b1;
              if (step_q != 2'd2) begin
                step_d = step_q + 2'd1; state_d = fmva_pkg::ST_PASS;
              end else begin
                ok_d = 1'b1;
              end
            end
          end
          fmva_pkg::MODE_DRUM_OF: begin
            if (!drum_q && step_q == 2'd0) begin
              ok_d = 1'b1;
            end else if (step_q == 2'd0 && keys_q != '0) begin
              ok_d = 1'b0;
            end else begin
              two_push = 1'b1; two_pv = 5'd6 + 5'(step_q);
              drum_d = 1'b0;
              if (step_q != 2'd2) begin
                step_d = step_q + 2'd1; state_d = fmva_pkg::ST_PASS;
              end else begin
                ok_d = 1'b1;
              end
            end
          end
          fmva_pkg::MODE_KEY_ON, fmva_pkg::MODE_KEY_OFF: begin
            if (used(alloc_q, ch_q)) begin
              ok_d = 1'b1;
              if (32'(ch_q) >= PHYS_CHANNELS) begin
                keys_d[3'(ch_q - 5'(PHYS_CHANNELS))] = (mode_q == fmva_pkg::MODE_KEY_ON);
              end
            end
          end
          default: ;
        endcase
      end
      fmva_pkg::ST_DONE: begin
        if (!out_stall_i) begin
          state_d = fmva_pkg::ST_IDLE;
        end
      end
      default: state_d = fmva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmva_pkg::ST_IDLE;
      step_q  <= '0;
      alloc_q <= '0;
      drum_q  <= 1'b0;
      keys_q  <= '0;
      for (int i = 0; i < PHYS_CHANNELS; i++) ktab_q[i] <= fmva_pkg::KindTwo;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      alloc_q <= alloc_d;
      drum_q  <= drum_d;
      keys_q  <= keys_d;
      ktab_q  <= ktab_d;
      ov_q    <= (state_d == fmva_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q <= ok_d; gr_q <= gr_d; mu_q <= mu_d;
    if (state_q == fmva_pkg::ST_IDLE && in_valid_i) begin
      mode_q <= mode_i; kind_q <= voice_kind_i; ch_q <= channel_id_i;
    end
  end

  assign in_stall_o        = (state_q != fmva_pkg::ST_IDLE);
  assign out_valid_o       = ov_q;
  assign ok_o              = ok_q;
  assign granted_channel_o = gr_q;
  assign mask_update_o     = mu_q;
  assign four_op_mask_o    = mask;

endmodule

// ----- src/fmva_checker.sv -----
// Port-level checker for the FM voice channel allocator, bound to the top level.
// Depends on fm_voice_channel_allocator ports only.
module fmva_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       ok_o,
  input logic [4:0] granted_channel_o,
  input logic       mask_update_o,
  input logic [5:0] four_op_mask_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_channel_o))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_mask_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mask_update_o |-> ok_o)
    else $error("mask update without grant");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> granted_channel_o == 5'd0)
    else $error("channel on refusal");

endmodule

bind fm_voice_channel_allocator fmva_checker u_fmva_checker (.*);
